// ===== hw/rtl/u8dec_pkg.sv =====
package u8dec_pkg;

  // Lead byte thresholds
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;

  // Value bit masks for each byte kind
  localparam logic [7:0] MASK_ASCII = 8'h7F;
  localparam logic [7:0] MASK_LEAD2 = 8'h1F;
  localparam logic [7:0] MASK_LEAD3 = 8'h0F;
  localparam logic [7:0] MASK_LEAD4 = 8'h07;
  localparam logic [7:0] MASK_CONT  = 8'h3F;

  localparam int unsigned CP_W = 21;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            decode_error;
    logic            final_result;
  } out_t;

endpackage

// ===== hw/rtl/u8dec_in_reg.sv =====
module u8dec_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  u8dec_pkg::in_t in_data,
  input  logic           advance,
  output logic           item_valid,
  output u8dec_pkg::in_t item
);
  import u8dec_pkg::*;

  // Hold the byte while the decode stage cannot move it on
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

endmodule

// ===== hw/rtl/u8dec_core.sv =====
module u8dec_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  u8dec_pkg::in_t  item,
  output logic            has_result,
  output u8dec_pkg::out_t result
);
  import u8dec_pkg::*;

  logic [1:0]      bytes_pending, bytes_pending_next;
  logic [CP_W-1:0] partial_value, partial_value_next;
  logic [1:0]      pend_dec;
  logic [CP_W-1:0] shifted;
  logic            open_seq;

  assign pend_dec = bytes_pending - 2'd1;
  assign shifted  = {partial_value[CP_W-7:0], 6'b0} | {{(CP_W-8){1'b0}}, item.in_byte & MASK_CONT};

  // Decode one byte against the sequence state
  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    has_result         = 1'b0;
    result             = '0;
    open_seq           = 1'b0;
    if (bytes_pending == 2'd0) begin
      if (item.in_byte < LEAD2_MIN) begin
        has_result          = 1'b1;
        result.code_point   = {{(CP_W-8){1'b0}}, item.in_byte & MASK_ASCII};
        result.final_result = item.end_of_buffer;
      end else if (item.in_byte < LEAD3_MIN) begin
        partial_value_next = {{(CP_W-8){1'b0}}, item.in_byte & MASK_LEAD2};
        bytes_pending_next = 2'd1;
        open_seq           = 1'b1;
      end else if (item.in_byte < LEAD4_MIN) begin
        partial_value_next = {{(CP_W-8){1'b0}}, item.in_byte & MASK_LEAD3};
        bytes_pending_next = 2'd2;
        open_seq           = 1'b1;
      end else begin
        partial_value_next = {{(CP_W-8){1'b0}}, item.in_byte & MASK_LEAD4};
        bytes_pending_next = 2'd3;
        open_seq           = 1'b1;
      end
    end else if (pend_dec == 2'd0) begin
      // last continuation byte completes the code point
      has_result          = 1'b1;
      result.code_point   = shifted;
      result.final_result = item.end_of_buffer;
      partial_value_next  = '0;
      bytes_pending_next  = 2'd0;
    end else begin
      partial_value_next = shifted;
      bytes_pending_next = pend_dec;
      open_seq           = 1'b1;
    end

    // buffer ended inside a sequence
    if (open_seq && item.end_of_buffer) begin
      has_result          = 1'b1;
      result              = '0;
      result.decode_error = 1'b1;
      result.final_result = 1'b1;
      partial_value_next  = '0;
      bytes_pending_next  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_value <= '0;
    end else if (advance) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

// ===== hw/rtl/u8dec_out_reg.sv =====
module u8dec_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load_valid,
  input  u8dec_pkg::out_t load_data,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output u8dec_pkg::out_t out_data
);
  import u8dec_pkg::*;

  // Register can take a new result when empty or being drained
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== hw/rtl/utf8_to_code_point_decoder_unit.sv =====
// UTF-8 byte stream to code point decoder.
// Input channel: in_valid / in_stall carry one byte per transaction in
// in_data, with end_of_buffer set on the last byte of a buffer.
// Output channel: out_valid / out_stall carry one result per transaction
// in out_data: a 21-bit code point, an error flag when the buffer ended
// inside a multi-byte sequence, and a flag on the buffer's last result.
// Lead and middle bytes of a sequence produce no output transaction,
// except an error result when end_of_buffer is set on one of them.
// A byte passes from the input register, loaded when it is accepted,
// through the combinational decode into the result register.
// Throughput: one byte per cycle while the receiver does not stall, the
// decode between the input and result registers being combinational.
// Reset (rst, synchronous) empties both registers and returns the decoder
// to the idle state with no sequence open.
// When the receiver stalls, the held result stays put; one more byte can
// be taken into the input register, after which in_stall rises until the
// result is taken.
module utf8_to_code_point_decoder_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  u8dec_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output u8dec_pkg::out_t out_data
);
  import u8dec_pkg::*;

  logic item_valid;
  in_t  item;
  logic out_ready;
  logic advance;
  logic has_result;
  out_t result;

  assign advance = item_valid && out_ready;

  u8dec_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  u8dec_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  u8dec_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (advance && has_result),
    .load_data  (result),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== bench/utf8_to_code_point_decoder_unit_tb.sv =====
`timescale 1ns / 100ps

module utf8_to_code_point_decoder_unit_tb;
  import u8dec_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1400;
  localparam int unsigned WDOG_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 8;

  // One queued byte: payload, idle cycles before it, and whether the
  // sender must first wait for every outstanding code point.
  typedef struct packed {
    in_t        data;
    logic [4:0] gap;
    logic       drain;
  } feed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  feed_t feed_q[$];
  out_t  cp_expect_q[$];
  feed_t cur;
  logic  loaded = 1'b0;
  logic  in_took = 1'b0;
  logic  out_took = 1'b0;
  int unsigned stall_left = 0;

  // Decoder shadow state
  logic [1:0]      cont_left = '0;
  logic [CP_W-1:0] cp_acc = '0;

  int unsigned n_queued = 0;
  int unsigned n_bytes = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          gen_calm = 1'b0;

  utf8_to_code_point_decoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Mostly short waits, sometimes long ones, none in calm stretches
  function automatic int unsigned pick_wait(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  // Advance the shadow decoder by one byte; queue the code point it yields
  function automatic void decode_byte(in_t it);
    out_t res;
    bit   have;
    have = 1'b0;
    res = '0;
    if (cont_left == 2'd0) begin
      if (it.in_byte < LEAD2_MIN) begin
        res.code_point = CP_W'(it.in_byte & MASK_ASCII);
        res.final_result = it.end_of_buffer;
        have = 1'b1;
      end else if (it.in_byte < LEAD3_MIN) begin
        cp_acc = CP_W'(it.in_byte & MASK_LEAD2);
        cont_left = 2'd1;
      end else if (it.in_byte < LEAD4_MIN) begin
        cp_acc = CP_W'(it.in_byte & MASK_LEAD3);
        cont_left = 2'd2;
      end else begin
        cp_acc = CP_W'(it.in_byte & MASK_LEAD4);
        cont_left = 2'd3;
      end
    end else begin
      // continuation: high bits are not checked
      cp_acc = {cp_acc[CP_W-7:0], 6'(it.in_byte & MASK_CONT)};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        res.code_point = cp_acc;
        res.final_result = it.end_of_buffer;
        cp_acc = '0;
        have = 1'b1;
      end
    end
    // buffer ran out inside a sequence
    if (!have && it.end_of_buffer) begin
      cont_left = '0;
      cp_acc = '0;
      res.decode_error = 1'b1;
      res.final_result = 1'b1;
      have = 1'b1;
    end
    if (have) cp_expect_q = {cp_expect_q, res};
  endfunction

  task automatic add_byte(logic [7:0] b, logic eob, logic drain);
    feed_t f;
    f.data.in_byte = b;
    f.data.end_of_buffer = eob;
    f.gap = 5'(pick_wait(gen_calm));
    f.drain = drain;
    feed_q = {feed_q, f};
    n_queued++;
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Sender: holds each transaction until taken, then waits out the next gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      loaded = 1'b0;
    end else if (!in_valid || in_took) begin
      if (!loaded && feed_q.size() != 0) begin
        cur = feed_q.pop_front();
        loaded = 1'b1;
      end
      if (loaded && cur.gap != 0) begin
        cur.gap = cur.gap - 5'd1;
        in_valid <= 1'b0;
      end else if (loaded && !(cur.drain && cp_expect_q.size() != 0)) begin
        in_valid <= 1'b1;
        in_data <= cur.data;
        loaded = 1'b0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: draws a stall length after each taken result
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_took) stall_left = pick_wait(((n_results / 150) % 4) == 3);
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted bytes, check accepted results, watchdog
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
      cont_left = '0;
      cp_acc = '0;
    end else begin
      in_took <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_data.decode_error) n_errors++;
        if (cp_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result cp=%06h err=%0b fin=%0b", $realtime,
                     out_data.code_point, out_data.decode_error, out_data.final_result);
        end else begin
          out_t want;
          want = cp_expect_q.pop_front();
          if (out_data.code_point !== want.code_point ||
              out_data.decode_error !== want.decode_error ||
              out_data.final_result !== want.final_result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp cp=%06h err=%0b fin=%0b got cp=%06h err=%0b fin=%0b",
                       $realtime, want.code_point, want.decode_error, want.final_result,
                       out_data.code_point, out_data.decode_error, out_data.final_result);
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_bytes++;
        decode_byte(in_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned seq_len;
    int unsigned cut;
    int unsigned n_seq;
    logic [7:0]  lead;
    logic        eob;

    // Directed: field extremes, every sequence length, stray and bad bytes
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b1, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);   // stray continuation as lead
    add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hC0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'hDF, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b1, 1'b0);   // completes on buffer end
    add_byte(8'hE0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'hEF, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hF0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'h80, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);   // top lead, continuation high bits ignored
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hC3, 1'b0, 1'b0);
    add_byte(8'h41, 1'b0, 1'b0);   // bad continuation taken as is
    add_byte(8'hC5, 1'b1, 1'b0);   // buffer ends right after a lead
    add_byte(8'hE1, 1'b0, 1'b0);
    add_byte(8'h82, 1'b1, 1'b0);   // buffer ends mid three-byte sequence

    // Random: mostly well-formed sequences, some truncated ones and noise
    n_seq = 0;
    while (n_queued < RANDOM_BYTES + 27) begin
      gen_calm = ((n_queued / 200) % 4) == 2;
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      end else begin
        case (kind)
          0, 1, 2: begin
            seq_len = 1;
            lead = ($urandom_range(0, 3) == 0) ? 8'h80 | 8'($urandom_range(0, 63))
                                                : 8'($urandom_range(0, 127));
          end
          3, 4: begin
            seq_len = 2;
            lead = 8'($urandom_range(8'hC0, 8'hDF));
          end
          5, 6: begin
            seq_len = 3;
            lead = 8'($urandom_range(8'hE0, 8'hEF));
          end
          default: begin
            seq_len = 4;
            lead = 8'($urandom_range(8'hF0, 8'hFF));
          end
        endcase
        cut = (seq_len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, seq_len - 1)
                                                         : seq_len;
        for (int unsigned i = 0; i < cut; i++) begin
          if (i != cut - 1) eob = 1'b0;
          else if (cut < seq_len) eob = ($urandom_range(0, 3) != 0);
          else eob = ($urandom_range(0, 5) == 0);
          // sender holds off now and then until the output side is empty
          add_byte((i == 0) ? lead : cont_byte(), eob, (i == 0) && (n_seq % 90 == 0));
        end
        n_seq++;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (feed_q.size() != 0 || loaded || in_valid || cp_expect_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes, checked %0d code points (%0d truncated-buffer errors).",
             n_bytes, n_results, n_errors);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
